[rtl/lss_pkg.sv]
`default_nettype none

package lss_pkg;

    // default number of entries held
    localparam int DEPTH_DEF = 32;

    // field widths
    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 6;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_PUSH   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DRAIN  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SHOW   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_PUSHED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_POPPED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SHOWN    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd5;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd6;

    // input word
    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [VALUE_W-1:0] value;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] data;
        logic [POS_W-1:0]          position;
        logic [COUNT_W-1:0]        count;
        logic                      is_empty;
        logic                      last;
    } t_out_word;

endpackage

`default_nettype wire

[rtl/lss_store.sv]
`default_nettype none

module lss_store
    import lss_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic               i_clk,
    input  wire logic               i_wr_en,
    input  wire logic [AW-1:0]      i_wr_addr,
    input  wire logic [VALUE_W-1:0] i_wr_data,
    input  wire logic [AW-1:0]      i_rd_addr,
    output logic      [VALUE_W-1:0] o_rd_data
);

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rd_data;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[rtl/lifo_stack_with_search_top.sv]
// push, or any action on an empty stack: the result word is registered as the input word is accepted
// drain and show: one result word per cycle while the output register is free to take it
// search: one entry compared per cycle unless a match waits on the output, each match held back until the next
// match or the finish state; the walk is paced by the single read port of the entry store and the output register
// reset clears the sequencer, the entry count and the output valid flag; the store is not cleared
`default_nettype none

module lifo_stack_with_search_top
    import lss_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_word
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WALK   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_addr, n_addr;
    logic [CW-1:0]       r_pos, n_pos;
    logic                r_pend_valid, n_pend_valid;
    logic [CW-1:0]       r_pend_pos, n_pend_pos;
    logic [ACTION_W-1:0] r_op, n_op;
    logic [VALUE_W-1:0]  r_key, n_key;
    logic                r_out_valid;
    t_out_word           r_out_word;

    logic                out_free;
    logic                in_acc;
    logic                emit;
    logic                step;
    logic                match;
    logic                full;
    logic [CW-1:0]       cnt_dec;
    logic                wr_en;
    logic [AW-1:0]       rd_addr;
    logic [VALUE_W-1:0]  rd_data;
    t_out_word           res;

    // entry store
    lss_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i_in_word.value),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // handshake
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && out_free;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign full    = (r_count == CW'(DEPTH));
    assign cnt_dec = r_count - CW'(1);
    assign match   = (rd_data == r_key);

    // sequencer and shared compare
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_addr       = r_addr;
        n_pos        = r_pos;
        n_pend_valid = r_pend_valid;
        n_pend_pos   = r_pend_pos;
        n_op         = r_op;
        n_key        = r_key;
        emit         = 1'b0;
        step         = 1'b0;
        wr_en        = 1'b0;
        rd_addr      = r_addr;
        res          = '0;

        case (r_state)
            S_IDLE: begin
                rd_addr = cnt_dec[AW-1:0];
                if (in_acc) begin
                    n_op  = i_in_word.action;
                    n_key = i_in_word.value;
                    if (i_in_word.action == ACT_PUSH) begin
                        emit     = 1'b1;
                        res.last = 1'b1;
                        if (full) begin
                            res.status = ST_FULL;
                        end else begin
                            wr_en      = 1'b1;
                            n_count    = r_count + CW'(1);
                            res.status = ST_PUSHED;
                        end
                    end else if (r_count == '0) begin
                        emit       = 1'b1;
                        res.last   = 1'b1;
                        res.status = ST_EMPTY;
                    end else begin
                        n_addr       = cnt_dec[AW-1:0];
                        n_pos        = CW'(1);
                        n_pend_valid = 1'b0;
                        n_state      = S_WALK;
                    end
                end
            end
            S_WALK: begin
                case (r_op)
                    ACT_DRAIN: begin
                        step = out_free;
                        if (step) begin
                            emit       = 1'b1;
                            n_count    = cnt_dec;
                            res.status = ST_POPPED;
                            res.data   = $signed(rd_data);
                            res.last   = (r_addr == '0);
                        end
                    end
                    ACT_SHOW: begin
                        step = out_free;
                        if (step) begin
                            emit         = 1'b1;
                            res.status   = ST_SHOWN;
                            res.data     = $signed(rd_data);
                            res.position = POS_W'(r_pos);
                            res.last     = (r_addr == '0);
                        end
                    end
                    default: begin
                        // a new match releases the one held back
                        if (match && r_pend_valid) begin
                            step = out_free;
                            if (step) begin
                                emit         = 1'b1;
                                res.status   = ST_FOUND;
                                res.position = POS_W'(r_pend_pos);
                            end
                        end else begin
                            step = 1'b1;
                        end
                        if (step && match) begin
                            n_pend_valid = 1'b1;
                            n_pend_pos   = r_pos;
                        end
                    end
                endcase
                // advance towards the bottom entry
                if (step) begin
                    n_addr  = r_addr - AW'(1);
                    n_pos   = r_pos + CW'(1);
                    rd_addr = r_addr - AW'(1);
                    if (r_addr == '0) begin
                        n_state = (r_op == ACT_SEARCH) ? S_FINISH : S_IDLE;
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    emit     = 1'b1;
                    res.last = 1'b1;
                    n_state  = S_IDLE;
                    if (r_pend_valid) begin
                        res.status   = ST_FOUND;
                        res.position = POS_W'(r_pend_pos);
                    end else begin
                        res.status = ST_NOTFOUND;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // count and empty flag as held after this word
        res.count    = COUNT_W'(n_count);
        res.is_empty = (n_count == '0);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // walk and payload registers
    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_pos      <= n_pos;
        r_pend_pos <= n_pend_pos;
        r_op       <= n_op;
        r_key      <= n_key;
        if (emit) begin
            r_out_word <= res;
        end
    end

    // checks
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE))
        else $error("input ready outside idle");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_walk_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (CW'(r_addr) < r_count))
        else $error("walk address beyond entries held");

    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == ST_POPPED && o_out_word.last)
        |-> o_out_word.is_empty)
        else $error("drain ended with entries left");

    a_word_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result word changed");

endmodule

`default_nettype wire

[verif/tb_top.sv]
`default_nettype none

module tb_top;
    import lss_pkg::*;

    localparam int          STACK_DEPTH = DEPTH_DEF;
    localparam int          WORDS_TOTAL = 370;
    localparam int          QUIET_FROM  = 310;
    localparam longint      LIMIT_TIME  = 64'd2_000_000 * 12;

    // expected results of the stack, worked out per accepted input word
    class lifo_scoreboard;
        logic signed [VALUE_W-1:0] entries [STACK_DEPTH];
        int unsigned               held;
        t_out_word                 awaited [$];
        int                        errors;
        int                        words_in;
        int                        words_out;
        int                        status_seen [8];

        function new();
            held      = 0;
            errors    = 0;
            words_in  = 0;
            words_out = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // count and empty flag follow the entries held at this point
        function void queue_result(logic [STATUS_W-1:0] status,
                                   logic signed [VALUE_W-1:0] data,
                                   int unsigned pos, logic last);
            t_out_word w;
            w.status   = status;
            w.data     = data;
            w.position = POS_W'(pos);
            w.count    = COUNT_W'(held);
            w.is_empty = (held == 0);
            w.last     = last;
            awaited.push_back(w);
        endfunction

        function void note_input(t_in_word w);
            int        hits;
            t_out_word tail;
            hits = 0;
            words_in++;
            if (w.action == ACT_PUSH) begin
                if (held >= STACK_DEPTH) begin
                    queue_result(ST_FULL, '0, 0, 1'b1);
                end else begin
                    entries[held] = w.value;
                    held++;
                    queue_result(ST_PUSHED, '0, 0, 1'b1);
                end
            end else if (held == 0) begin
                queue_result(ST_EMPTY, '0, 0, 1'b1);
            end else if (w.action == ACT_DRAIN) begin
                // pop everything, top first
                while (held > 0) begin
                    held--;
                    queue_result(ST_POPPED, entries[held], 0, held == 0);
                end
            end else if (w.action == ACT_SHOW) begin
                for (int i = 0; i < held; i++)
                    queue_result(ST_SHOWN, entries[held-1-i], i + 1, i + 1 == held);
            end else begin
                // search: every match from the top, last flag on the final one
                for (int i = 0; i < held; i++) begin
                    if (entries[held-1-i] == w.value) begin
                        queue_result(ST_FOUND, '0, i + 1, 1'b0);
                        hits++;
                    end
                end
                if (hits == 0) begin
                    queue_result(ST_NOTFOUND, '0, 0, 1'b1);
                end else begin
                    tail      = awaited.pop_back();
                    tail.last = 1'b1;
                    awaited.push_back(tail);
                end
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 25) $display("mismatch: %s", msg);
        endtask

        task check_result(t_out_word got);
            t_out_word want;
            words_out++;
            if (awaited.size() == 0) begin
                report($sformatf("result word with nothing awaited: status %0d data %0d",
                                 got.status, got.data));
                return;
            end
            want = awaited.pop_front();
            status_seen[want.status]++;
            if (got.status !== want.status)
                report($sformatf("word %0d status %0d, expected %0d",
                                 words_out, got.status, want.status));
            if (got.data !== want.data)
                report($sformatf("word %0d data %0d, expected %0d",
                                 words_out, got.data, want.data));
            if (got.position !== want.position)
                report($sformatf("word %0d position %0d, expected %0d",
                                 words_out, got.position, want.position));
            if (got.count !== want.count)
                report($sformatf("word %0d count %0d, expected %0d",
                                 words_out, got.count, want.count));
            if (got.is_empty !== want.is_empty)
                report($sformatf("word %0d is_empty %0b, expected %0b",
                                 words_out, got.is_empty, want.is_empty));
            if (got.last !== want.last)
                report($sformatf("word %0d last %0b, expected %0b",
                                 words_out, got.last, want.last));
        endtask
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_word out_word;
    bit        quiet     = 1'b0;
    int        fills     = 0;

    lifo_scoreboard sb = new();

    lifo_stack_with_search_top #(
        .DEPTH (STACK_DEPTH)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    // clock
    always #6 clk = ~clk;

    // result side check
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_word);
    end

    // result side back-pressure in bursts
    initial begin : ready_bursts
        int n;
        wait (rst_n);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 17);
                repeat (n) begin
                    @(negedge clk);
                    out_ready <= 1'b0;
                end
            end else begin
                n = $urandom_range(1, 24);
                repeat (n) begin
                    @(negedge clk);
                    out_ready <= 1'b1;
                end
            end
        end
    end

    // one input word, with an occasional random gap ahead of it
    task send_word(input logic [ACTION_W-1:0] act, input logic signed [VALUE_W-1:0] val);
        t_in_word w;
        int       gap;
        w.action = act;
        w.value  = val;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            repeat (gap) begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        sb.note_input(w);
    endtask

    // values biased towards extremes and small repeats so searches hit
    function automatic logic signed [VALUE_W-1:0] pool_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            4, 5:    return $urandom_range(1, 6);
            default: return $urandom();
        endcase
    endfunction

    task random_query();
        case ($urandom_range(0, 5))
            0: send_word(ACT_SHOW, $urandom());
            1, 2: begin
                if (sb.held > 0)
                    send_word(ACT_SEARCH, sb.entries[$urandom_range(0, sb.held - 1)]);
                else
                    send_word(ACT_SEARCH, pool_value());
            end
            3: send_word(ACT_SEARCH, pool_value());
            4: send_word(ACT_DRAIN, $urandom());
            default: send_word(ACT_SEARCH, $urandom());
        endcase
    endtask

    // push to capacity, try a few refused pushes, two random queries, then drain it
    task fill_stack();
        fills++;
        while (sb.held < STACK_DEPTH) send_word(ACT_PUSH, pool_value());
        repeat ($urandom_range(1, 3)) send_word(ACT_PUSH, $urandom());
        random_query();
        random_query();
        send_word(ACT_DRAIN, $urandom());
    endtask

    // stimulus
    initial begin : stimulus
        int pick;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // actions on an empty stack
        send_word(ACT_DRAIN, 32'sh0);
        send_word(ACT_SHOW, 32'sh7fff_ffff);
        send_word(ACT_SEARCH, 32'sh0);
        // extremes, with a duplicated maximum
        send_word(ACT_PUSH, 32'sh8000_0000);
        send_word(ACT_PUSH, 32'sh7fff_ffff);
        send_word(ACT_PUSH, 32'sh0);
        send_word(ACT_PUSH, -32'sd1);
        send_word(ACT_PUSH, 32'sh7fff_ffff);
        send_word(ACT_SHOW, 32'sh0);
        send_word(ACT_SEARCH, 32'sh7fff_ffff);
        send_word(ACT_SEARCH, 32'sh1234_5678);
        send_word(ACT_SEARCH, 32'sh8000_0000);
        send_word(ACT_SEARCH, -32'sd1);
        send_word(ACT_DRAIN, -32'sd1);
        // alternating bit patterns
        send_word(ACT_PUSH, 32'sh5555_5555);
        send_word(ACT_PUSH, 32'shaaaa_aaaa);
        send_word(ACT_SEARCH, 32'shaaaa_aaaa);
        send_word(ACT_SEARCH, 32'sh5555_5554);
        send_word(ACT_SHOW, 32'shffff_ffff);
        send_word(ACT_DRAIN, 32'sh0);

        // random part, starting with a full stack
        fill_stack();
        while (sb.words_in < WORDS_TOTAL) begin
            if (sb.words_in >= QUIET_FROM) quiet = 1'b1;
            pick = $urandom_range(0, 19);
            if (pick < 10) begin
                repeat ($urandom_range(1, 8)) send_word(ACT_PUSH, pool_value());
                repeat ($urandom_range(1, 3)) random_query();
            end else if (pick < 12 && fills < 3) begin
                fill_stack();
            end else if (pick < 16) begin
                repeat ($urandom_range(1, 6))
                    send_word(ACTION_W'($urandom_range(0, 3)), $urandom());
            end else begin
                random_query();
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;

        // drain the expectations, then allow for a full walk
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (2 * STACK_DEPTH + 8) @(posedge clk);
        if (sb.awaited.size() != 0)
            sb.report($sformatf("%0d result words never arrived", sb.awaited.size()));

        $display("run covered %0d input words and %0d result words, %0d fills to capacity",
                 sb.words_in, sb.words_out, fills);
        $display("pushed %0d, refused %0d, popped %0d, shown %0d, found %0d, missed %0d, empty %0d",
                 sb.status_seen[ST_PUSHED], sb.status_seen[ST_FULL],
                 sb.status_seen[ST_POPPED], sb.status_seen[ST_SHOWN],
                 sb.status_seen[ST_FOUND], sb.status_seen[ST_NOTFOUND],
                 sb.status_seen[ST_EMPTY]);
        if (sb.errors == 0) begin
            $display("PASS lifo_stack_with_search_top");
        end else begin
            $display("FAIL lifo_stack_with_search_top");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #(LIMIT_TIME);
        $display("timeout with %0d result words outstanding", sb.awaited.size());
        $display("FAIL lifo_stack_with_search_top");
        $finish;
    end

endmodule

`default_nettype wire

[lifo_stack_with_search_top.f]
rtl/lss_pkg.sv
rtl/lss_store.sv
rtl/lifo_stack_with_search_top.sv
verif/tb_top.sv
